### design/lstq_pkg.sv
`timescale 1ns / 1ps

package lstq_pkg;

    localparam int DEF_SET_DEPTH = 16;
    localparam int DEF_ADDR_BITS = 64;

    localparam int KIND_W       = 2;
    localparam int IN_TDATA_W   = 64;
    localparam int HELD_COUNT_W = 5;
    localparam int OUT_TDATA_W  = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACQUIRE = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_QUERY   = 2'd2
    } t_kind;

    // per-beat command broadcast to every cell of the table
    typedef struct packed {
        logic push;   // append the key at the first free cell
        logic pull;   // drop the matching cell, later cells move down one
    } t_cell_ctl;

endpackage

### design/lstq_cell.sv
`timescale 1ns / 1ps

module lstq_cell #(
    parameter int ADDR_BITS = lstq_pkg::DEF_ADDR_BITS,
    parameter int CNT_W     = 5,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  lstq_pkg::t_cell_ctl  i_ctl,
    input  logic [ADDR_BITS-1:0] i_key,
    input  logic [CNT_W-1:0]     i_count,
    input  logic                 i_hit,
    output logic                 o_hit,
    input  logic [ADDR_BITS-1:0] i_next_addr,
    output logic [ADDR_BITS-1:0] o_addr
);
    import lstq_pkg::*;

    logic [ADDR_BITS-1:0] r_addr;
    logic                 w_valid;
    logic                 w_self_hit;

    // cells are kept packed, so occupancy follows from the fill count
    assign w_valid    = CNT_W'(IDX) < i_count;
    assign w_self_hit = w_valid && (r_addr == i_key);
    // hit anywhere at or below this cell
    assign o_hit      = i_hit || w_self_hit;
    assign o_addr     = r_addr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pull && o_hit) begin
            r_addr <= i_next_addr;
        end else if (i_ctl.push && (CNT_W'(IDX) == i_count)) begin
            r_addr <= i_key;
        end
    end

endmodule

### design/lockset_table_with_set_queries.sv
`timescale 1ns / 1ps

// lockset table with streamed set queries
// input beats carry a lock address in tdata, the kind in tuser (acquire,
// release, query) and the end of a query run in tlast. every input beat gives
// exactly one output beat: held count, membership, dropped flag, and on the
// last beat of a query run the empty-intersection and equal-sets flags.
// the table is a chain of cells, one address each, all compared against the
// key at once; a release shifts the cells above the match down by one.
// each output beat is registered in the cycle after its input beat is taken;
// one beat per cycle is sustained while the receiver takes them: the output
// register frees as it is taken; cells compare, ripple hits, shift per beat.
// reset empties the table and clears the query counters; addresses in the
// cells are not cleared, only the fill count marks them used.
// when the receiver stalls, the output beat holds and o_s_tready drops until
// the beat is taken.
module lockset_table_with_set_queries #(
    parameter int SET_DEPTH = lstq_pkg::DEF_SET_DEPTH,
    parameter int ADDR_BITS = lstq_pkg::DEF_ADDR_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [lstq_pkg::IN_TDATA_W-1:0]    i_s_tdata,  // lock_addr
    input  logic [lstq_pkg::KIND_W-1:0]        i_s_tuser,  // kind
    input  logic                               i_s_tlast,  // run_last
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // held_count[4:0], is_member, dropped, intersection_empty, sets_equal, zeros
    output logic [lstq_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                               o_m_tlast   // result_last
);
    import lstq_pkg::*;

    localparam int CNT_W  = $clog2(SET_DEPTH + 1);
    localparam int SEEN_W = $clog2(SET_DEPTH + 2);

    logic [CNT_W-1:0]     r_count, n_count;
    logic [SEEN_W-1:0]    r_seen, n_seen;
    logic [CNT_W-1:0]     r_hits, n_hits;

    logic                 r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic                 r_out_last, n_out_last;

    logic                 w_accept;
    logic [ADDR_BITS-1:0] w_key;
    t_cell_ctl            w_ctl;
    logic                 w_member;
    logic                 w_full;

    logic [SET_DEPTH:0]   w_hit_chain;
    logic [ADDR_BITS-1:0] w_cell_addr [SET_DEPTH];

    assign w_key    = i_s_tdata[ADDR_BITS-1:0];
    assign w_full   = (r_count == CNT_W'(SET_DEPTH));
    assign w_member = w_hit_chain[SET_DEPTH];
    assign w_accept = i_s_tvalid && o_s_tready;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    assign w_hit_chain[0] = 1'b0;

    for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
        logic [ADDR_BITS-1:0] w_next;
        if (g == SET_DEPTH - 1) begin : g_top
            assign w_next = w_cell_addr[g];
        end else begin : g_mid
            assign w_next = w_cell_addr[g+1];
        end
        lstq_cell #(
            .ADDR_BITS (ADDR_BITS),
            .CNT_W     (CNT_W),
            .IDX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_key       (w_key),
            .i_count     (r_count),
            .i_hit       (w_hit_chain[g]),
            .o_hit       (w_hit_chain[g+1]),
            .i_next_addr (w_next),
            .o_addr      (w_cell_addr[g])
        );
    end

    always_comb begin
        logic dropped;
        logic inter_empty;
        logic equal;
        logic member_out;
        logic rlast;

        n_count     = r_count;
        n_seen      = r_seen;
        n_hits      = r_hits;
        w_ctl       = '0;
        dropped     = 1'b0;
        inter_empty = 1'b0;
        equal       = 1'b0;
        member_out  = 1'b0;
        rlast       = 1'b0;

        unique case (t_kind'(i_s_tuser))
            KIND_ACQUIRE: begin
                member_out = w_member;
                if (!w_member) begin
                    if (w_full) begin
                        dropped = 1'b1;
                    end else begin
                        w_ctl.push = w_accept;
                        n_count    = r_count + CNT_W'(1);
                    end
                end
            end
            KIND_RELEASE: begin
                member_out = w_member;
                if (w_member) begin
                    w_ctl.pull = w_accept;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            KIND_QUERY: begin
                member_out = w_member;
                if (r_seen < SEEN_W'(SET_DEPTH + 1)) begin
                    n_seen = r_seen + SEEN_W'(1);
                end
                if (w_member && (r_hits < CNT_W'(SET_DEPTH))) begin
                    n_hits = r_hits + CNT_W'(1);
                end
                if (i_s_tlast) begin
                    rlast       = 1'b1;
                    inter_empty = (n_hits == '0);
                    equal       = (r_count != '0) && (SEEN_W'(r_count) == n_seen)
                                  && (SEEN_W'(n_hits) == n_seen);
                    n_seen      = '0;
                    n_hits      = '0;
                end
            end
            default: begin
            end
        endcase

        n_out_data = {(OUT_TDATA_W - HELD_COUNT_W - 4)'(0), equal, inter_empty,
                      dropped, member_out, HELD_COUNT_W'(n_count)};
        n_out_last = rlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_seen      <= '0;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_seen      <= n_seen;
                r_hits      <= n_hits;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SET_DEPTH))
        else $error("fill count beyond table depth");

    a_hits_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SEEN_W'(r_hits) <= r_seen)
        else $error("query hits exceed query items seen");

    a_run_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_s_tuser == KIND_QUERY) && i_s_tlast
        |=> (r_seen == '0) && (r_hits == '0))
        else $error("query counters not cleared after last beat");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[HELD_COUNT_W+1]
        |-> (r_count == CNT_W'(SET_DEPTH)))
        else $error("dropped acquire while table not full");

    a_equal_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[HELD_COUNT_W+3] |-> !r_out_data[HELD_COUNT_W+2])
        else $error("equal sets reported with empty intersection");

endmodule
